/* hw/rtl/gbr_pkg.sv */
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the RGB Gaussian blur
// Beat payload types, register indexes, default geometry and the
// coefficient generator used to build the per-cell coefficient tables.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // default build values
  localparam int MAX_KERNEL_DEF = 11;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int COEF_FRAC_DEF  = 16;

  // register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [2:0]  RADIUS_RST = 3'd2;

  // largest geometry the counters cover
  localparam logic [11:0] GEOM_CAP = 12'd2048;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_t;

  // input beat
  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  // output beat
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic        frame_last;
  } result_t;

  // per-beat bookkeeping carried down the pipeline
  typedef struct packed {
    logic        interior;
    logic [10:0] col;
    logic [10:0] row;
    logic        last;
  } meta_t;

  // pipeline control handed to every cell
  typedef struct packed {
    logic adv;
    logic shift;
  } ctl_t;

  localparam longint unsigned Q31 = 64'd1 << 31;

  // shift-subtract quotient, elaboration use only
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    int k;
    q   = 0;
    rem = 0;
    for (k = 63; k >= 0; k--) begin
      rem = {rem[62:0], n[k]};
      if (rem >= d) begin
        rem  = rem - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) in Q1.31 by Taylor series, f in Q1.31
  function automatic longint unsigned exp_series(input longint unsigned fq);
    longint sum;
    longint unsigned term;
    int i;
    sum  = longint'(Q31);
    term = Q31;
    for (i = 1; i <= 30; i++) begin
      term = udiv((term * fq) >> 31, longint'(i));
      if ((i & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // exp(-num/den) in Q1.31
  function automatic longint unsigned exp_neg(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned whole;
    longint unsigned rem;
    longint unsigned res;
    longint unsigned e1;
    longint unsigned k;
    whole = udiv(num, den);
    rem   = num - whole * den;
    res   = exp_series(udiv(rem << 31, den));
    e1    = exp_series(Q31);
    for (k = 0; k < whole; k++) res = (res * e1) >> 31;
    return res;
  endfunction

  // rounded coefficient for radius r at offsets (ay, ax)
  function automatic longint unsigned coef(input longint unsigned r,
                                           input longint unsigned ay,
                                           input longint unsigned ax,
                                           input int frac);
    longint unsigned m;
    longint unsigned d;
    longint unsigned e;
    longint unsigned x;
    m = 30 * r + 65;
    d = m * m;
    e = exp_neg(5000 * (ax * ax + ay * ay), d);
    x = udiv(e * 64'd166075000, 64'd104348 * d);
    return (x + (64'd1 << (30 - frac))) >> (31 - frac);
  endfunction

  // coefficient seen at window position (y, x) for radius r
  function automatic longint unsigned coef_at(input int win, input int r,
                                              input int y, input int x,
                                              input int frac);
    int base;
    int ay;
    int ax;
    base = win - 1 - 2 * r;
    if (y < base || x < base) return 64'd0;
    ay = (y - base > r) ? (y - base - r) : (r - (y - base));
    ax = (x - base > r) ? (x - base - r) : (r - (x - base));
    return coef(longint'(r), longint'(ay), longint'(ax), frac);
  endfunction

endpackage

/* hw/rtl/gbr_line_mem.sv */
// ----------------------------------------------------------------------------
// gbr_line_mem: one image line of the line store
// Single write port, one registered read port, read returns the old word
// when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module gbr_line_mem #(
  parameter int DEPTH = gbr_pkg::MAX_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  gbr_pkg::pixel_t wdata,
  output gbr_pkg::pixel_t rdata
);

  gbr_pkg::pixel_t mem [DEPTH];

  // write and read-first registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hw/rtl/gbr_cell.sv */
// ----------------------------------------------------------------------------
// gbr_cell: one window column of the blur
// Holds a column of pixels, passes it to its left neighbour on every shift
// and forms the weighted column sum of each channel over two stages.
// ----------------------------------------------------------------------------
module gbr_cell #(
  parameter int WIN            = gbr_pkg::MAX_KERNEL_DEF,
  parameter int POS            = 0,
  parameter int COEF_FRAC_BITS = gbr_pkg::COEF_FRAC_DEF,
  localparam int RADII = (WIN + 1) / 2,
  localparam int RW    = (RADII > 1) ? $clog2(RADII) : 1,
  localparam int PW    = 8 + COEF_FRAC_BITS,
  localparam int CSW   = PW + $clog2(WIN + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  gbr_pkg::ctl_t   ctl,
  input  logic [RW-1:0]   radius,
  input  gbr_pkg::pixel_t col_in  [WIN],
  output gbr_pkg::pixel_t col_out [WIN],
  output logic [CSW-1:0]  col_sum [3]
);

  gbr_pkg::pixel_t           col     [WIN];
  logic [COEF_FRAC_BITS-1:0] coef_tab [WIN][RADII];
  logic [COEF_FRAC_BITS-1:0] coef_sel [WIN];
  logic [PW-1:0]             prod    [WIN][3];
  logic [CSW-1:0]            sum_next [3];

  // coefficient tables for this column, one entry per radius
  for (genvar y = 0; y < WIN; y++) begin : g_row
    for (genvar rr = 0; rr < RADII; rr++) begin : g_rad
      localparam longint unsigned CV =
        gbr_pkg::coef_at(WIN, rr, y, POS, COEF_FRAC_BITS);
      assign coef_tab[y][rr] = CV[COEF_FRAC_BITS-1:0];
    end
    assign coef_sel[y] = coef_tab[y][radius];
  end

  // column register, shifted in from the right neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < WIN; y++) col[y] <= '0;
    end else if (ctl.shift) begin
      for (int y = 0; y < WIN; y++) col[y] <= col_in[y];
    end
  end

  assign col_out = col;

  // products of each pixel with its coefficient, positions outside the kernel give zero
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int y = 0; y < WIN; y++) begin
        prod[y][0] <= (coef_sel[y] == '0) ? '0
                      : PW'(col[y].pixel_red)   * PW'(coef_sel[y]);
        prod[y][1] <= (coef_sel[y] == '0) ? '0
                      : PW'(col[y].pixel_green) * PW'(coef_sel[y]);
        prod[y][2] <= (coef_sel[y] == '0) ? '0
                      : PW'(col[y].pixel_blue)  * PW'(coef_sel[y]);
      end
    end
  end

  // column sum per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = '0;
      for (int y = 0; y < WIN; y++) sum_next[k] = sum_next[k] + CSW'(prod[y][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < 3; k++) col_sum[k] <= sum_next[k];
    end
  end

endmodule

/* hw/rtl/gaussian_blur_rgb.sv */
// Throughput: one pixel per cycle while the output is not stalled;
// the output register stalls the whole pipe. Registered steps in order:
// line store read, window shift, products, column sums, window sum, clamp.
// Reset clears counters, window, valid flags and sets 640x480, radius 2;
// the line memories keep their contents and are not cleared.
// ----------------------------------------------------------------------------
// gaussian_blur_rgb: streaming RGB Gaussian blur
// Line memories feed a row of window-column cells; the cell sums are added,
// scaled and clamped into the output register.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb #(
  parameter int MAX_KERNEL     = gbr_pkg::MAX_KERNEL_DEF,
  parameter int MAX_WIDTH      = gbr_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = gbr_pkg::COEF_FRAC_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  gbr_pkg::pixel_t  in_pixel,
  output logic             out_valid,
  input  logic             out_stall,
  output gbr_pkg::result_t out_result,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [11:0]      wr_data
);

  localparam int WIN   = MAX_KERNEL;
  localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int RADII = (MAX_KERNEL + 1) / 2;
  localparam int RW    = (RADII > 1) ? $clog2(RADII) : 1;
  localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW    = 8 + COEF_FRAC_BITS;
  localparam int CSW   = PW + $clog2(WIN + 1);
  localparam int TW    = PW + $clog2(WIN * WIN + 1);
  localparam logic [11:0] WCAP = (MAX_WIDTH < 2048) ? 12'(MAX_WIDTH) : gbr_pkg::GEOM_CAP;

  // configuration registers
  logic [11:0] img_w;
  logic [11:0] img_h;
  logic [2:0]  k_rad;

  // effective geometry
  logic [11:0]   w_eff;
  logic [11:0]   h_eff;
  logic [RW-1:0] r_eff;
  logic [11:0]   r12;

  // frame position
  logic [10:0]   col_cnt;
  logic [10:0]   row_cnt;
  logic [SW-1:0] rmod;
  logic          col_end;
  logic          row_end;
  logic          geom_wr;

  // handshake
  logic adv;
  logic accept;

  // pipeline
  logic            s1_valid;
  gbr_pkg::pixel_t s1_pix;
  logic [SW-1:0]   s1_rmod;
  gbr_pkg::meta_t  s1_meta;
  gbr_pkg::meta_t  meta_next;
  logic            s2_valid, s3_valid, s4_valid, s5_valid;
  gbr_pkg::meta_t  s2_meta, s3_meta, s4_meta, s5_meta;
  logic [TW-1:0]   s5_sum [3];
  logic [TW-1:0]   tot_next [3];
  logic [7:0]      clamp [3];

  // line store and window
  gbr_pkg::pixel_t rd [LINES];
  gbr_pkg::pixel_t new_col [WIN];
  gbr_pkg::pixel_t win_col [WIN][WIN];
  logic [CSW-1:0]  csum [WIN][3];
  gbr_pkg::ctl_t   ctl;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= gbr_pkg::WIDTH_RST;
      img_h <= gbr_pkg::HEIGHT_RST;
      k_rad <= gbr_pkg::RADIUS_RST;
    end else if (wr_en) begin
      unique case (gbr_pkg::reg_idx_t'(wr_index))
        gbr_pkg::REG_WIDTH:  img_w <= wr_data;
        gbr_pkg::REG_HEIGHT: img_h <= wr_data;
        gbr_pkg::REG_RADIUS: k_rad <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign geom_wr = wr_en && (wr_index == gbr_pkg::REG_WIDTH ||
                             wr_index == gbr_pkg::REG_HEIGHT);

  // saturate geometry and radius
  always_comb begin
    w_eff = (img_w == '0) ? 12'd1 : img_w;
    if (w_eff > WCAP) w_eff = WCAP;
    h_eff = (img_h == '0) ? 12'd1 : img_h;
    if (h_eff > gbr_pkg::GEOM_CAP) h_eff = gbr_pkg::GEOM_CAP;
    r_eff = (k_rad > 3'(RADII - 1)) ? RW'(RADII - 1) : RW'(k_rad);
    r12   = 12'(r_eff);
  end

  assign col_end = (12'(col_cnt) + 12'd1) >= w_eff;
  assign row_end = (12'(row_cnt) + 12'd1) >= h_eff;

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      col_cnt <= '0;
      row_cnt <= '0;
      rmod    <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt <= '0;
        if (row_end) begin
          row_cnt <= '0;
          rmod    <= '0;
        end else begin
          row_cnt <= row_cnt + 11'd1;
          rmod    <= (rmod == SW'(LINES - 1)) ? '0 : rmod + SW'(1);
        end
      end else begin
        col_cnt <= col_cnt + 11'd1;
      end
    end
  end

  // result bookkeeping for the incoming beat
  always_comb begin
    meta_next.interior = (12'(col_cnt) >= (r12 << 1)) && (12'(row_cnt) >= (r12 << 1));
    meta_next.col      = col_cnt - 11'(r_eff);
    meta_next.row      = row_cnt - 11'(r_eff);
    meta_next.last     = col_end && row_end;
  end

  // line memories, one per slot
  for (genvar m = 0; m < LINES; m++) begin : g_line
    gbr_line_mem #(.DEPTH(MAX_WIDTH)) u_mem (
      .clk   (clk),
      .en    (adv),
      .we    (accept && (rmod == SW'(m))),
      .addr  (AW'(col_cnt)),
      .wdata (in_pixel),
      .rdata (rd[m])
    );
  end

  // stage 1: pixel waits for its line reads
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix  <= in_pixel;
      s1_rmod <= rmod;
      s1_meta <= meta_next;
    end
  end

  // new window column: rotate line reads by the current row slot
  assign new_col[WIN-1] = s1_pix;
  for (genvar j = 0; j < WIN - 1; j++) begin : g_rot
    localparam int IM = (WIN - 1 - j) % LINES;
    logic [SW:0] slot_sum;
    logic [SW:0] slot;
    assign slot_sum = {1'b0, s1_rmod} + (SW + 1)'(LINES - IM);
    assign slot     = (slot_sum >= (SW + 1)'(LINES)) ? slot_sum - (SW + 1)'(LINES) : slot_sum;
    assign new_col[j] = rd[slot[SW-1:0]];
  end

  assign ctl.adv   = adv;
  assign ctl.shift = adv && s1_valid;

  // chain of window-column cells, newest on the right
  for (genvar x = 0; x < WIN; x++) begin : g_cell
    gbr_pkg::pixel_t cin [WIN];
    if (x == WIN - 1) begin : g_newest
      assign cin = new_col;
    end else begin : g_older
      assign cin = win_col[x + 1];
    end
    gbr_cell #(
      .WIN            (WIN),
      .POS            (x),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .radius  (r_eff),
      .col_in  (cin),
      .col_out (win_col[x]),
      .col_sum (csum[x])
    );
  end

  // stages 2 to 5: window shift, products, column sums, window sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_meta.interior;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot_next[k] = '0;
      for (int x = 0; x < WIN; x++) tot_next[k] = tot_next[k] + TW'(csum[x][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta <= s1_meta;
      s3_meta <= s2_meta;
      s4_meta <= s3_meta;
      s5_meta <= s4_meta;
      for (int k = 0; k < 3; k++) s5_sum[k] <= tot_next[k];
    end
  end

  // drop the fraction and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clamp[k] = (|(s5_sum[k] >> (COEF_FRAC_BITS + 8))) ? 8'hFF
                 : s5_sum[k][COEF_FRAC_BITS +: 8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result.out_red    <= clamp[0];
      out_result.out_green  <= clamp[1];
      out_result.out_blue   <= clamp[2];
      out_result.out_col    <= s5_meta.col;
      out_result.out_row    <= s5_meta.row;
      out_result.frame_last <= s5_meta.last;
    end
  end

  // checks
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    12'(col_cnt) < w_eff) else $error("column counter beyond image width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    12'(row_cnt) < h_eff) else $error("row counter beyond image height");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s5_valid) && $stable(s5_meta))
    else $error("pipeline moved while output stalled");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && s1_meta.interior |=> s2_valid)
    else $error("interior beat lost at window shift");

endmodule
